// ===== rtl/two_phase_adc_frame_averager_top_macros.svh =====
// Assertion macros used by the frame averager top level.
`ifndef TWO_PHASE_ADC_FRAME_AVERAGER_TOP_MACROS_SVH
`define TWO_PHASE_ADC_FRAME_AVERAGER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define TPAFA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define TPAFA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tpafa_pkg.sv =====
// Shared types and constants of the two-phase ADC frame averager.
`timescale 1ns / 1ps

package tpafa_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned DATA_W     = 12;
	localparam int unsigned CHAN_W     = 4;
	localparam int unsigned CHAN_LSB   = 13;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 4;

	localparam int unsigned AVG_FRAMES_DEFAULT = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SLOT0_CHANNEL = 2'd0,
		REG_SLOT1_CHANNEL = 2'd1,
		REG_SLOT0_PHASE   = 2'd2,
		REG_SLOT1_PHASE   = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		PHASE_A = 1'b0,
		PHASE_B = 1'b1
	} phase_t;

	typedef enum logic {
		STATUS_VALID = 1'b0,
		STATUS_EMPTY = 1'b1
	} status_t;

	localparam logic [CHAN_W-1:0] SLOT0_CHANNEL_RESET = 4'd0;
	localparam logic [CHAN_W-1:0] SLOT1_CHANNEL_RESET = 4'd1;

endpackage

// ===== rtl/tpafa_cdiv.sv =====
// Divides a frame sum by the fixed frame count with a reciprocal multiply.
`timescale 1ns / 1ps

module tpafa_cdiv import tpafa_pkg::*; #(
	parameter int unsigned AVG_FRAMES = AVG_FRAMES_DEFAULT,
	localparam int unsigned SumW = DATA_W + $clog2(AVG_FRAMES)
) (
	input  logic [SumW-1:0]   dividend,
	output logic [DATA_W-1:0] quotient
);

	// With the shift set to the sum width plus log2 of the divisor and the
	// multiplier rounded up, the truncated product is the exact floor for
	// every sum that the accumulator can hold.
	localparam int unsigned DivShift = SumW + $clog2(AVG_FRAMES);
	localparam int unsigned MulW     = SumW + 1;
	localparam int unsigned ProdW    = SumW + MulW;
	localparam longint unsigned DivMul =
		((64'd1 << DivShift) + AVG_FRAMES - 1) / AVG_FRAMES;

	logic [ProdW-1:0] prod;

	assign prod     = ProdW'(dividend) * ProdW'(DivMul);
	assign quotient = prod[DivShift +: DATA_W];

endmodule

// ===== rtl/two_phase_adc_frame_averager_top.sv =====
// Top level of the two-phase ADC frame averager.
`timescale 1ns / 1ps

// Takes one transaction per clock cycle. Each accepted transaction is held in an
// input register and processed from there: conversion words update the frame
// capture, the running sums and the frame counter and give no result; a read
// request loads the output register as it leaves the input register. Conversion
// words never stall. A read waits in the input register only while the output
// register holds a result not yet taken, and then the input side stalls with it.
// The average is the frame sum times a fixed reciprocal (a single multiplier per
// phase); a frame that completes a group loads the divider input registers, the
// quotient is then latched as the average, and a read before that takes it directly.
`include "two_phase_adc_frame_averager_top_macros.svh"

module two_phase_adc_frame_averager_top import tpafa_pkg::*; #(
	parameter int unsigned AVG_FRAMES = AVG_FRAMES_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  func,
	input  logic [WORD_W-1:0]     conv_word,
	input  logic                  frame_end,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  status,
	output logic [DATA_W-1:0]     current_a,
	output logic [DATA_W-1:0]     current_b,
	output logic [COUNT_W-1:0]    frames_since_read,
	output logic [COUNT_W-1:0]    frames_total
);

	localparam int unsigned SumW = DATA_W + $clog2(AVG_FRAMES);
	localparam int unsigned CntW = ($clog2(AVG_FRAMES) > 0) ? $clog2(AVG_FRAMES) : 1;

	// Configuration
	logic [CHAN_W-1:0] slot0_ch_q, slot1_ch_q;
	phase_t            slot0_ph_q, slot1_ph_q;

	// Input register
	logic              valid_s1;
	logic              func_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic [DATA_W-1:0] data_s1;
	logic              last_s1;

	// Frame and accumulator state
	logic [DATA_W-1:0]  val_a_q, val_b_q;
	logic               seen_a_q, seen_b_q;
	logic [SumW-1:0]    sum_a_q, sum_b_q;
	logic [CntW-1:0]    good_cnt_q;
	logic [SumW-1:0]    div_sum_a_q, div_sum_b_q;
	logic               div_go_q;
	logic [DATA_W-1:0]  avg_a_q, avg_b_q;
	logic               avg_valid_q;
	logic [COUNT_W-1:0] frame_cnt_q;
	logic [COUNT_W-1:0] snap_q;

	// Output register
	logic               out_valid_q;
	status_t            status_q;
	logic [DATA_W-1:0]  cur_a_q, cur_b_q;
	logic [COUNT_W-1:0] since_q, total_q;

	// Combinational
	logic              adv, conv_go, read_go;
	logic              hit0, hit1, hit;
	phase_t            cap_phase;
	logic              cap_a, cap_b;
	logic [DATA_W-1:0] val_a_n, val_b_n;
	logic              seen_a_n, seen_b_n, good;
	logic [SumW-1:0]   sum_a_n, sum_b_n;
	logic              group_done;
	logic [DATA_W-1:0] quot_a, quot_b;
	logic [DATA_W-1:0] rd_a, rd_b;

	tpafa_cdiv #(.AVG_FRAMES(AVG_FRAMES)) u_div_a (
		.dividend (div_sum_a_q),
		.quotient (quot_a)
	);

	tpafa_cdiv #(.AVG_FRAMES(AVG_FRAMES)) u_div_b (
		.dividend (div_sum_b_q),
		.quotient (quot_b)
	);

	// A read moves on only when the output register is free or being emptied.
	assign adv      = valid_s1 && (!func_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign conv_go  = adv && !func_s1;
	assign read_go  = adv && func_s1;

	always_comb begin
		hit0       = (chan_s1 == slot0_ch_q);
		hit1       = (chan_s1 == slot1_ch_q);
		hit        = hit0 || hit1;
		// Slot zero takes priority when both slots name the same channel.
		cap_phase  = hit0 ? slot0_ph_q : slot1_ph_q;
		cap_a      = hit && (cap_phase == PHASE_A);
		cap_b      = hit && (cap_phase == PHASE_B);
		val_a_n    = cap_a ? data_s1 : val_a_q;
		val_b_n    = cap_b ? data_s1 : val_b_q;
		seen_a_n   = seen_a_q || cap_a;
		seen_b_n   = seen_b_q || cap_b;
		good       = seen_a_n && seen_b_n;
		sum_a_n    = sum_a_q + SumW'(val_a_n);
		sum_b_n    = sum_b_q + SumW'(val_b_n);
		group_done = (good_cnt_q == CntW'(AVG_FRAMES - 1));
		// A group closed in the previous cycle has not reached the average yet.
		rd_a       = div_go_q ? quot_a : avg_a_q;
		rd_b       = div_go_q ? quot_b : avg_b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot0_ch_q <= SLOT0_CHANNEL_RESET;
			slot1_ch_q <= SLOT1_CHANNEL_RESET;
			slot0_ph_q <= PHASE_A;
			slot1_ph_q <= PHASE_B;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_SLOT0_CHANNEL: begin
					slot0_ch_q <= cfg_wdata[CHAN_W-1:0];
				end
				REG_SLOT1_CHANNEL: begin
					slot1_ch_q <= cfg_wdata[CHAN_W-1:0];
				end
				REG_SLOT0_PHASE: begin
					slot0_ph_q <= phase_t'(cfg_wdata[0]);
				end
				REG_SLOT1_PHASE: begin
					slot1_ph_q <= phase_t'(cfg_wdata[0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			chan_s1 <= conv_word[CHAN_LSB +: CHAN_W];
			data_s1 <= conv_word[DATA_W-1:0];
			last_s1 <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_a_q     <= '0;
			val_b_q     <= '0;
			seen_a_q    <= 1'b0;
			seen_b_q    <= 1'b0;
			sum_a_q     <= '0;
			sum_b_q     <= '0;
			good_cnt_q  <= '0;
			div_go_q    <= 1'b0;
			avg_valid_q <= 1'b0;
			frame_cnt_q <= '0;
			snap_q      <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (conv_go) begin
				if (last_s1) begin
					val_a_q     <= '0;
					val_b_q     <= '0;
					seen_a_q    <= 1'b0;
					seen_b_q    <= 1'b0;
					frame_cnt_q <= frame_cnt_q + COUNT_W'(1);
					if (good) begin
						if (group_done) begin
							div_go_q    <= 1'b1;
							avg_valid_q <= 1'b1;
							sum_a_q     <= '0;
							sum_b_q     <= '0;
							good_cnt_q  <= '0;
						end else begin
							sum_a_q    <= sum_a_n;
							sum_b_q    <= sum_b_n;
							good_cnt_q <= good_cnt_q + CntW'(1);
						end
					end
				end else begin
					val_a_q  <= val_a_n;
					val_b_q  <= val_b_n;
					seen_a_q <= seen_a_n;
					seen_b_q <= seen_b_n;
				end
			end
			if (read_go && avg_valid_q) begin
				snap_q <= frame_cnt_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (conv_go && last_s1 && good && group_done) begin
			div_sum_a_q <= sum_a_n;
			div_sum_b_q <= sum_b_n;
		end
		if (div_go_q) begin
			avg_a_q <= quot_a;
			avg_b_q <= quot_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (read_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read_go) begin
			if (avg_valid_q) begin
				status_q <= STATUS_VALID;
				cur_a_q  <= rd_a;
				cur_b_q  <= rd_b;
				since_q  <= frame_cnt_q - snap_q;
				total_q  <= frame_cnt_q;
			end else begin
				status_q <= STATUS_EMPTY;
				cur_a_q  <= '0;
				cur_b_q  <= '0;
				since_q  <= '0;
				total_q  <= '0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign status            = status_q;
	assign current_a         = cur_a_q;
	assign current_b         = cur_b_q;
	assign frames_since_read = since_q;
	assign frames_total      = total_q;

	`TPAFA_ASSERT_NOW(a_stall_only_on_read, !in_ready, valid_s1 && func_s1 && out_valid_q && !out_ready, "input stalled without a blocked read")
	`TPAFA_ASSERT_NOW(a_div_implies_valid, div_go_q, avg_valid_q, "average latch pending without valid flag")
	`TPAFA_ASSERT_NEXT(a_snapshot_matches_total, read_go && avg_valid_q, snap_q == frames_total, "read snapshot differs from reported total")
	`TPAFA_ASSERT_NEXT(a_counter_only_on_frame_end, !(conv_go && last_s1), $stable(frame_cnt_q), "frame counter moved without a frame end")
	`TPAFA_ASSERT_NOW(a_empty_read_zero, out_valid_q && (status_q == STATUS_EMPTY), (cur_a_q == '0) && (since_q == '0) && (total_q == '0), "empty read carries nonzero fields")

endmodule
